// ===== sv/atmm_pkg.sv =====
package atmm_pkg;

   // Field widths that the interface fixes.
   localparam int CHANNEL_BITS = 3;
   localparam int WARM_BITS    = 2;

   // Defaults for the top-level parameters.
   localparam int WINDOW_LEN_DEF  = 12;
   localparam int SAMPLE_BITS_DEF = 10;

   // Window shape.
   localparam int TRIM         = 2;
   localparam int QUICK_LEN    = 3;
   localparam int FULL_WARMUP  = 2;
   localparam int QUICK_WARMUP = 1;

   // Filter mode register codes.
   localparam logic MODE_FULL  = 1'b0;
   localparam logic MODE_QUICK = 1'b1;

   // Tag that travels with each kept sample from the front end to the sorter.
   typedef struct packed {
      logic [CHANNEL_BITS-1:0] channel;
      logic                    first;
      logic                    last;
      logic                    quick;
   } atmm_ctrl_type;

endpackage

// ===== sv/atmm_front.sv =====
module atmm_front #(
   parameter int SAMPLE_BITS = atmm_pkg::SAMPLE_BITS_DEF,
   parameter int WINDOW_LEN  = atmm_pkg::WINDOW_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SAMPLE_BITS-1:0]     req_sample,
   input  logic [atmm_pkg::CHANNEL_BITS-1:0] req_channel,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_data,
   input  logic                       queue_full,
   output logic                       push,
   output logic [SAMPLE_BITS-1:0]     push_sample,
   output atmm_pkg::atmm_ctrl_type    push_ctrl
);
   import atmm_pkg::*;

   localparam int FILL_W = $clog2(WINDOW_LEN + 1);

   logic              mode_ff, mode_in;
   logic [WARM_BITS-1:0] warm_ff, warm_in;
   logic [FILL_W-1:0] win_ff, win_in;
   logic [WARM_BITS-1:0] warm_target;
   logic [FILL_W-1:0] len_target;
   logic              accept;
   logic              warming;
   logic              last;

   // Per-mode window shape.
   assign warm_target = (mode_ff == MODE_QUICK) ? WARM_BITS'(QUICK_WARMUP)
                                                : WARM_BITS'(FULL_WARMUP);
   assign len_target  = (mode_ff == MODE_QUICK) ? FILL_W'(QUICK_LEN)
                                                : FILL_W'(WINDOW_LEN);

   // A mode write goes first; a request offered with it waits until the write is taken.
   assign req_ready = !queue_full && !csr_valid;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign warming   = warm_ff < warm_target;
   assign last      = (win_ff + FILL_W'(1)) == len_target;

   // Warm-up samples are dropped here; kept samples go to the queue.
   assign push                = accept && !warming;
   assign push_sample         = req_sample;
   assign push_ctrl.channel   = req_channel;
   assign push_ctrl.first     = win_ff == '0;
   assign push_ctrl.last      = last;
   assign push_ctrl.quick     = mode_ff == MODE_QUICK;

   // Window counters; a mode write restarts the window.
   always_comb begin
      mode_in = mode_ff;
      warm_in = warm_ff;
      win_in  = win_ff;
      if (csr_valid && csr_ready) begin
         mode_in = csr_data;
         warm_in = '0;
         win_in  = '0;
      end else if (accept) begin
         if (warming) begin
            warm_in = warm_ff + WARM_BITS'(1);
         end else if (last) begin
            warm_in = '0;
            win_in  = '0;
         end else begin
            win_in = win_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FULL;
         warm_ff <= '0;
         win_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         warm_ff <= warm_in;
         win_ff  <= win_in;
      end
   end

endmodule

// ===== sv/atmm_queue.sv =====
module atmm_queue #(
   parameter int SAMPLE_BITS = atmm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [SAMPLE_BITS-1:0]  push_sample,
   input  atmm_pkg::atmm_ctrl_type push_ctrl,
   output logic                    full,
   output logic                    pop_valid,
   input  logic                    pop,
   output logic [SAMPLE_BITS-1:0]  pop_sample,
   output atmm_pkg::atmm_ctrl_type pop_ctrl
);
   import atmm_pkg::*;

   logic [SAMPLE_BITS-1:0] sample_ff [2];
   atmm_ctrl_type          ctrl_ff   [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic                   do_pop;

   assign full       = count_ff == 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign do_pop     = pop && pop_valid;
   assign pop_sample = sample_ff[rd_ptr_ff];
   assign pop_ctrl   = ctrl_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         sample_ff[wr_ptr_ff] <= push_sample;
         ctrl_ff[wr_ptr_ff]   <= push_ctrl;
      end
   end

endmodule

// ===== sv/atmm_back.sv =====
module atmm_back #(
   parameter int SAMPLE_BITS = atmm_pkg::SAMPLE_BITS_DEF,
   parameter int WINDOW_LEN  = atmm_pkg::WINDOW_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [SAMPLE_BITS-1:0]     in_sample,
   input  atmm_pkg::atmm_ctrl_type    in_ctrl,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [SAMPLE_BITS-1:0]     rsp_filtered,
   output logic [atmm_pkg::CHANNEL_BITS-1:0] rsp_channel
);
   import atmm_pkg::*;

   localparam int KEPT     = WINDOW_LEN - 2 * TRIM;
   localparam int SUM_W    = SAMPLE_BITS + $clog2(KEPT);
   localparam int IDX_W    = $clog2(WINDOW_LEN);
   localparam int FILL_W   = $clog2(WINDOW_LEN + 1);
   localparam int RECIP_SH = SUM_W + $clog2(KEPT);
   localparam int RECIP    = (2 ** RECIP_SH + KEPT - 1) / KEPT;
   localparam int PROD_W   = 2 * SUM_W + 1;

   typedef enum logic [2:0] {
      ST_INSERT = 3'b001,
      ST_SUM    = 3'b010,
      ST_DIV    = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [SAMPLE_BITS-1:0] sorted_ff [WINDOW_LEN];
   logic [SAMPLE_BITS-1:0] ins       [WINDOW_LEN];
   logic                   gt        [WINDOW_LEN];
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [FILL_W-1:0]      n;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [SUM_W-1:0]       acc_ff, acc_in;
   logic [PROD_W-1:0]      prod;
   logic                   out_free;
   logic                   take;
   logic                   out_load;
   logic [SAMPLE_BITS-1:0] out_value;
   logic [CHANNEL_BITS-1:0] out_chan;
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] out_data_ff;
   logic [CHANNEL_BITS-1:0] out_chan_ff;
   logic [CHANNEL_BITS-1:0] chan_ff;

   assign out_free = !out_valid_ff || rsp_ready;
   assign n        = in_ctrl.first ? '0 : fill_ff;

   // A quick-mode window closes at once and needs the output register.
   assign in_ready = (state_ff == ST_INSERT) &&
                     (!(in_ctrl.last && in_ctrl.quick) || out_free);
   assign take     = in_valid && in_ready;

   // Sorted insertion: entries above the new sample move up one place.
   always_comb begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         gt[i] = (FILL_W'(i) < n) && (sorted_ff[i] > in_sample);
      end
      if ((n != '0) && !gt[0]) begin
         ins[0] = sorted_ff[0];
      end else begin
         ins[0] = in_sample;
      end
      for (int i = 1; i < WINDOW_LEN; i++) begin
         if ((FILL_W'(i) < n) && !gt[i]) begin
            ins[i] = sorted_ff[i];
         end else if (FILL_W'(i) <= n) begin
            ins[i] = gt[i-1] ? sorted_ff[i-1] : in_sample;
         end else begin
            ins[i] = sorted_ff[i];
         end
      end
   end

   // Divide the sum by the kept-sample count through a constant reciprocal;
   // the rounded-up reciprocal is exact for every sum that fits in SUM_W bits.
   assign prod = PROD_W'(acc_ff) * PROD_W'(RECIP);

   // Sequencer: insert; a full window then sums the middle entries and scales the sum, a quick window takes its median.
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      out_load  = 1'b0;
      out_value = prod[RECIP_SH +: SAMPLE_BITS];
      out_chan  = chan_ff;
      case (state_ff)
         ST_INSERT: begin
            if (take) begin
               fill_in = in_ctrl.last ? '0 : n + FILL_W'(1);
               if (in_ctrl.last && in_ctrl.quick) begin
                  out_load  = 1'b1;
                  out_value = ins[1];
                  out_chan  = in_ctrl.channel;
               end else if (in_ctrl.last) begin
                  state_in = ST_SUM;
                  idx_in   = IDX_W'(TRIM);
                  acc_in   = '0;
               end
            end
         end
         ST_SUM: begin
            acc_in = acc_ff + SUM_W'(sorted_ff[idx_ff]);
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(WINDOW_LEN - TRIM - 1)) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_INSERT;
            end
         end
         default: begin
            state_in = ST_INSERT;
         end
      endcase
   end

   // Output register holds a result until the receiver takes it.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INSERT;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      acc_ff <= acc_in;
      if (take) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            sorted_ff[i] <= ins[i];
         end
         chan_ff <= in_ctrl.channel;
      end
      if (out_load) begin
         out_data_ff <= out_value;
         out_chan_ff <= out_chan;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_filtered = out_data_ff;
   assign rsp_channel  = out_chan_ff;

endmodule

// ===== sv/adc_trimmed_mean_median_filter_unit.sv =====
// ADC trimmed-mean / median window filter.
// The req channel carries one ADC sample with its channel tag per request.
// Each window first discards warm-up samples (two in full mode, one in quick
// mode), then collects WINDOW_LEN samples (full) or three (quick). One result
// leaves on the rsp channel per completed window, tagged with the channel of
// the window's last sample. The csr channel writes the one-bit filter mode
// (0 = trimmed mean, 1 = median of three); a write restarts the window.
// A front end drops warm-up samples and tags the rest, a two-entry queue
// decouples it from the sorter, which inserts one sample per cycle into a
// sorted register chain while it is not busy with a result. Requests are
// taken at one per cycle while the queue has room and no mode write is
// offered. A quick-mode result passes from the queue straight to the output
// register. After its last sample, a full-mode window sums the middle
// WINDOW_LEN - 4 samples and scales the sum by a constant reciprocal, while
// the sorter takes no sample. Reset sets full mode and restarts the window.
// A stalled receiver holds the result in the output register; the sorter
// keeps filling the next window and waits only when another result is ready
// to leave.
module adc_trimmed_mean_median_filter_unit #(
   parameter int WINDOW_LEN  = atmm_pkg::WINDOW_LEN_DEF,
   parameter int SAMPLE_BITS = atmm_pkg::SAMPLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0: sample, channel, zero fill.
   input  logic [((SAMPLE_BITS + atmm_pkg::CHANNEL_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0: filtered, result_channel, zero fill.
   output logic [((SAMPLE_BITS + atmm_pkg::CHANNEL_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_data
);
   import atmm_pkg::*;

   localparam int DATA_W = ((SAMPLE_BITS + CHANNEL_BITS + 7) / 8) * 8;

   logic                    queue_full;
   logic                    push;
   logic [SAMPLE_BITS-1:0]  push_sample;
   atmm_ctrl_type           push_ctrl;
   logic                    pop_valid;
   logic                    pop;
   logic [SAMPLE_BITS-1:0]  pop_sample;
   atmm_ctrl_type           pop_ctrl;
   logic [SAMPLE_BITS-1:0]  filtered;
   logic [CHANNEL_BITS-1:0] result_channel;

   atmm_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WINDOW_LEN  (WINDOW_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .req_channel (req_tdata[SAMPLE_BITS+CHANNEL_BITS-1:SAMPLE_BITS]),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .queue_full  (queue_full),
      .push        (push),
      .push_sample (push_sample),
      .push_ctrl   (push_ctrl)
   );

   atmm_queue #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_sample (push_sample),
      .push_ctrl   (push_ctrl),
      .full        (queue_full),
      .pop_valid   (pop_valid),
      .pop         (pop),
      .pop_sample  (pop_sample),
      .pop_ctrl    (pop_ctrl)
   );

   atmm_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WINDOW_LEN  (WINDOW_LEN)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (pop_valid),
      .in_ready     (pop),
      .in_sample    (pop_sample),
      .in_ctrl      (pop_ctrl),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_filtered (filtered),
      .rsp_channel  (result_channel)
   );

   // Pack the result with zero fill up to whole bytes.
   assign rsp_tdata = DATA_W'({result_channel, filtered});

endmodule
